// ----- rtl/core/sis_pkg.sv -----
// sis_pkg: shared types and codes for the sorted integer set
// holds request/result payload structs, opcodes, sequencer states
// no dependencies
package sis_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_ERASE  = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] key;
    } t_req;

    typedef struct packed {
        logic       was_present;
        logic       full_reject;
        logic [6:0] element_count;
    } t_res;

    // top level to engine
    typedef struct packed {
        logic start;
        logic ack;
    } t_eng_ctl;

    // engine to top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_eng_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_CMP,
        ST_DECIDE,
        ST_UP_PRIME,
        ST_UP,
        ST_INS,
        ST_DN_PRIME,
        ST_DN,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/sorted_integer_set.sv -----
// sorted_integer_set: top level of the sorted signed-key set
// request handshake, result register, instance of sis_engine
// depends on sis_pkg, sis_engine
//
//   channel   direction  handshake                   payload
//   request   in         i_req_valid / o_req_stall   i_req (opcode, key)
//   result    out        o_res_valid / i_res_stall   o_res (was_present, full_reject,
//                                                           element_count)
//
// one request at a time; with n keys held a request first runs a binary search
//   on the single store read port and shared compare
// an insert then moves up to n entries one per cycle through that port, after
//   a priming read when anything moves, and then places the key
// an erase moves up to n-1 entries, after the priming read when anything moves
// the done state and then the idle state follow before the next transfer
// the result lands in an output register; the next request is taken while it waits
// reset empties the set at once (count to zero), store contents need no clearing
// a stalled result holds the engine in its final state until the register frees up
module sorted_integer_set #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  sis_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_stall,
    output sis_pkg::t_res o_res
);
    import sis_pkg::*;

    t_eng_ctl  eng_ctl;
    t_eng_stat eng_stat;
    t_res      eng_res;

    logic r_res_valid, n_res_valid;
    t_res r_res;
    logic take;

    // request transfer starts the engine only when it sits idle
    assign eng_ctl.start = i_req_valid && !eng_stat.busy;

    // result moves to the output register when it is empty or being drained
    assign take        = eng_stat.done && (!r_res_valid || !i_res_stall);
    assign eng_ctl.ack = take;

    sis_engine #(
        .CAPACITY (CAPACITY)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (eng_ctl),
        .i_req   (i_req),
        .o_stat  (eng_stat),
        .o_res   (eng_res)
    );

    always_comb begin
        n_res_valid = r_res_valid;
        if (take) begin
            n_res_valid = 1'b1;
        end else if (!i_res_stall) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= n_res_valid;
        end
        if (take) begin
            r_res <= eng_res;
        end
    end

    // busy engine holds off further requests
    assign o_req_stall = eng_stat.busy;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ----- rtl/core/sis_engine.sv -----
// sis_engine: key store and sequencer for the sorted integer set
// binary search with one shared compare, then one-entry-per-cycle shifts
// depends on sis_pkg
module sis_engine #(
    parameter int CAPACITY = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sis_pkg::t_eng_ctl i_ctl,
    input  sis_pkg::t_req     i_req,
    output sis_pkg::t_eng_stat o_stat,
    output sis_pkg::t_res     o_res
);
    import sis_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // key store, ascending by signed value, no reset
    logic [31:0] r_mem [CAPACITY];
    logic [31:0] r_rd_data;

    t_state             r_state, n_state;
    logic [1:0]         r_op, n_op;
    logic signed [31:0] r_key, n_key;
    logic [CW-1:0]      r_lo, n_lo;
    logic [CW-1:0]      r_hi, n_hi;
    logic [CW-1:0]      r_mid, n_mid;
    logic [CW-1:0]      r_j, n_j;
    logic [CW-1:0]      r_count, n_count;
    logic               r_hit, n_hit;
    logic               r_reject, n_reject;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;

    logic [CW:0]   w_sum;
    logic [CW-1:0] w_mid;
    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_j_m2;
    logic [CW:0]   w_j_p2;
    logic [CW-1:0] w_lo_p1;
    logic [CW+6:0] w_cnt_ext;

    assign w_sum    = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid    = w_sum[CW:1];
    assign w_cnt_m1 = r_count - CW'(1);
    assign w_j_m2   = r_j - CW'(2);
    assign w_j_p2   = {1'b0, r_j} + (CW+1)'(2);
    assign w_lo_p1  = r_lo + CW'(1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_j      <= n_j;
        r_hit    <= n_hit;
        r_reject <= n_reject;
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_j      = r_j;
        n_count  = r_count;
        n_hit    = r_hit;
        n_reject = r_reject;
        rd_en    = 1'b0;
        rd_addr  = '0;
        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_data  = r_key;

        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_op     = i_req.opcode;
                    n_key    = i_req.key;
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_hit    = 1'b0;
                    n_reject = 1'b0;
                    n_state  = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (r_lo < r_hi) begin
                    rd_en   = 1'b1;
                    rd_addr = w_mid[AW-1:0];
                    n_mid   = w_mid;
                    n_state = ST_CMP;
                end else begin
                    n_state = ST_DECIDE;
                end
            end
            ST_CMP: begin
                // hit tracks the entry that last pulled hi down
                if ($signed(r_rd_data) < r_key) begin
                    n_lo = r_mid + CW'(1);
                end else begin
                    n_hi  = r_mid;
                    n_hit = (r_rd_data == r_key);
                end
                n_state = ST_SEARCH;
            end
            ST_DECIDE: begin
                if (r_op == OP_INSERT && !r_hit) begin
                    if (r_count == CAP_CNT) begin
                        n_reject = 1'b1;
                        n_state  = ST_DONE;
                    end else if (r_count == r_lo) begin
                        n_state = ST_INS;
                    end else begin
                        n_state = ST_UP_PRIME;
                    end
                end else if (r_op == OP_ERASE && r_hit) begin
                    if (w_lo_p1 == r_count) begin
                        n_count = w_cnt_m1;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_DN_PRIME;
                    end
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_UP_PRIME: begin
                rd_en   = 1'b1;
                rd_addr = w_cnt_m1[AW-1:0];
                n_j     = r_count;
                n_state = ST_UP;
            end
            ST_UP: begin
                wr_en   = 1'b1;
                wr_addr = r_j[AW-1:0];
                wr_data = r_rd_data;
                if ((r_j - CW'(1)) == r_lo) begin
                    n_state = ST_INS;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = w_j_m2[AW-1:0];
                    n_j     = r_j - CW'(1);
                end
            end
            ST_INS: begin
                wr_en   = 1'b1;
                wr_addr = r_lo[AW-1:0];
                wr_data = r_key;
                n_count = r_count + CW'(1);
                n_state = ST_DONE;
            end
            ST_DN_PRIME: begin
                rd_en   = 1'b1;
                rd_addr = w_lo_p1[AW-1:0];
                n_j     = r_lo;
                n_state = ST_DN;
            end
            ST_DN: begin
                wr_en   = 1'b1;
                wr_addr = r_j[AW-1:0];
                wr_data = r_rd_data;
                if (w_j_p2 == {1'b0, r_count}) begin
                    n_count = w_cnt_m1;
                    n_state = ST_DONE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = w_j_p2[AW-1:0];
                    n_j     = r_j + CW'(1);
                end
            end
            ST_DONE: begin
                if (i_ctl.ack) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_cnt_ext = {7'd0, r_count};

    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.done = (r_state == ST_DONE);

    assign o_res.was_present   = r_hit;
    assign o_res.full_reject   = r_reject;
    assign o_res.element_count = w_cnt_ext[6:0];

endmodule

// ----- rtl/core/sis_checker.sv -----
// sis_checker: port-level checks for sorted_integer_set
// bound to the top level below
// depends on sis_pkg
module sis_checker #(
    parameter int CAPACITY = 64
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_req_valid,
    input logic          o_req_stall,
    input sis_pkg::t_req i_req,
    input logic          o_res_valid,
    input logic          i_res_stall,
    input sis_pkg::t_res o_res
);
    import sis_pkg::*;

    localparam logic [6:0] CAP_LOW = 7'(CAPACITY % 128);

    // stalled result stays put
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=> o_res_valid && $stable(o_res))
        else $error("result changed while stalled");

    // an accepted request keeps the block busy the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && !o_req_stall |=> o_req_stall)
        else $error("request accepted without going busy");

    // a refused insert never reports the key as present
    a_reject_new_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_res.full_reject && o_res.was_present))
        else $error("refusal flagged for present key");

    // a refusal only comes from a full store
    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.full_reject |-> o_res.element_count == CAP_LOW)
        else $error("refusal with store not full");

    // no result right out of reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res_valid)
        else $error("result valid after reset");

endmodule

bind sorted_integer_set sis_checker #(
    .CAPACITY (CAPACITY)
) u_sis_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_stall (o_req_stall),
    .i_req       (i_req),
    .o_res_valid (o_res_valid),
    .i_res_stall (i_res_stall),
    .o_res       (o_res)
);
